>>> rtl/mf2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared sizes, types and helpers of the 2D median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 3;

   localparam int PIX_W     = 8;
   localparam int DIM_W     = 11;                        // frame size registers
   localparam int RAD_W     = 2;                         // radius register
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int EROW_W    = $clog2(MAX_HEIGHT);
   localparam int POS_W     = DIM_W + 2;                 // signed tap positions
   localparam int WIN_SIDE  = 2 * MAX_RADIUS + 1;
   localparam int WIN_TAPS  = WIN_SIDE * WIN_SIDE;
   localparam int SIDE_W    = $clog2(WIN_SIDE);
   localparam int RING_BITS = $clog2(WIN_SIDE);
   localparam int RING_ROWS = 1 << RING_BITS;
   localparam int LEAD_W    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
   localparam int RANK_W    = $clog2(WIN_TAPS);
   localparam int CNT_W     = $clog2(WIN_TAPS + 1);
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = $clog2(Q_DEPTH);
   localparam int OUT_DEPTH = 16;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);

   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

   typedef logic [PIX_W-1:0]            pixel_type;
   typedef pixel_type [WIN_SIDE-1:0]    col_vec_type;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [RAD_W-1:0] r;
   } cfg_type;

   // one column of the window plus the output position it completes
   typedef struct packed {
      col_vec_type       vec;
      logic              emit;
      logic [COL_W-1:0]  x;
      logic [EROW_W-1:0] y;
      logic              last;
   } col_entry_type;

   // Unused taps are zero, so the median rank moves up by their count.
   function automatic logic [RANK_W-1:0] median_rank(input logic [RAD_W-1:0] r);
      int rr;
      rr = int'(r);
      return RANK_W'(WIN_TAPS - 1 - 2 * rr * (rr + 1));
   endfunction

endpackage
`default_nettype wire

>>> rtl/mf2d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf2d_front
// Takes pixel beats, tracks frame positions, writes the row banks and
// gathers one vertical window column per beat.
// ----------------------------------------------------------------------------
module mf2d_front (
   input  logic                           clock,
   input  logic                           reset,
   input  mf2d_pkg::cfg_type              cfg,
   input  logic                           restart,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_cmd,
   input  logic [mf2d_pkg::PIX_W-1:0]     req_pixel,
   input  logic [mf2d_pkg::Q_AW:0]        q_count,
   output logic                           q_push,
   output mf2d_pkg::col_entry_type        q_data
);
   import mf2d_pkg::*;

   logic                  accept, in_frame, step, wr_en, emit, last;
   logic [COL_W-1:0]      in_col_ff, in_col_in, emit_col_ff, emit_col_in;
   logic [DIM_W-1:0]      in_row_ff, in_row_in, col_inc, ecol_inc;
   logic [EROW_W-1:0]     emit_row_ff, emit_row_in;
   logic [LEAD_W-1:0]     lead_ff, lead_in, lead_inc, lead_target;
   logic [RAD_W:0]        two_r;
   logic [POS_W-1:0]      row_pos [WIN_SIDE];
   logic [WIN_SIDE-1:0]   vmask_in, usepix_in, vmask_ff, usepix_ff;
   logic [RING_BITS-1:0]  sel_in [WIN_SIDE];
   logic [RING_BITS-1:0]  sel_ff [WIN_SIDE];
   logic                  s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [COL_W-1:0]      s1_x_ff;
   logic [EROW_W-1:0]     s1_y_ff;
   pixel_type             s1_pixel_ff;
   pixel_type             rd_ff [RING_ROWS];
   logic [Q_AW+1:0]       occupancy;

   assign occupancy = (Q_AW+2)'(q_count) + (Q_AW+2)'(s1_valid_ff);
   assign full      = occupancy >= (Q_AW+2)'(Q_DEPTH);
   assign accept    = push & ~full;
   assign in_frame  = in_row_ff < cfg.h;
   // a flush beat inside the frame is dropped without effect
   assign step      = accept & ~(in_frame & req_cmd);
   assign wr_en     = step & in_frame;

   assign col_inc     = DIM_W'(in_col_ff) + 1'b1;
   assign ecol_inc    = DIM_W'(emit_col_ff) + 1'b1;
   assign lead_inc    = lead_ff + 1'b1;
   assign lead_target = LEAD_W'(cfg.r) * LEAD_W'(cfg.w) + LEAD_W'(cfg.r) + 1'b1;
   assign emit        = lead_inc >= lead_target;
   assign last        = (DIM_W'(emit_col_ff) == cfg.w - 1'b1) &&
                        (DIM_W'(emit_row_ff) == cfg.h - 1'b1);
   assign two_r       = {cfg.r, 1'b0};

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      emit_col_in = emit_col_ff;
      emit_row_in = emit_row_ff;
      lead_in     = lead_ff;
      if (restart || (step && emit && last)) begin
         in_col_in   = '0;
         in_row_in   = '0;
         emit_col_in = '0;
         emit_row_in = '0;
         lead_in     = '0;
      end else if (step) begin
         if (col_inc >= cfg.w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = col_inc[COL_W-1:0];
         end
         if (emit) begin
            if (ecol_inc >= cfg.w) begin
               emit_col_in = '0;
               emit_row_in = emit_row_ff + 1'b1;
            end else begin
               emit_col_in = ecol_inc[COL_W-1:0];
            end
         end else begin
            lead_in = lead_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
         lead_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         emit_col_ff <= emit_col_in;
         emit_row_ff <= emit_row_in;
         lead_ff     <= lead_in;
         s1_valid_ff <= step;
      end
   end

   // window row dy of the column ending at the current input row
   always_comb begin
      for (int dy = 0; dy < WIN_SIDE; dy++) begin
         row_pos[dy]   = POS_W'(in_row_ff) - POS_W'(two_r) + POS_W'(dy);
         sel_in[dy]    = row_pos[dy][RING_BITS-1:0];
         usepix_in[dy] = (RAD_W+1)'(dy) == two_r;
         vmask_in[dy]  = ((RAD_W+1)'(dy) <= two_r) && !row_pos[dy][POS_W-1] &&
                         (row_pos[dy] < POS_W'(cfg.h));
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_pixel_ff <= req_pixel;
         s1_emit_ff  <= emit;
         s1_last_ff  <= last;
         s1_x_ff     <= emit_col_ff;
         s1_y_ff     <= emit_row_ff;
         vmask_ff    <= vmask_in;
         usepix_ff   <= usepix_in;
         sel_ff      <= sel_in;
      end
   end

   for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
      pixel_type bank_mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (wr_en && (in_row_ff[RING_BITS-1:0] == RING_BITS'(b))) begin
            bank_mem[in_col_ff] <= req_pixel;
         end
         if (step) begin
            rd_ff[b] <= bank_mem[in_col_ff];
         end
      end
   end

   always_comb begin
      q_data.emit = s1_emit_ff;
      q_data.last = s1_last_ff;
      q_data.x    = s1_x_ff;
      q_data.y    = s1_y_ff;
      for (int dy = 0; dy < WIN_SIDE; dy++) begin
         if (!vmask_ff[dy]) begin
            q_data.vec[dy] = '0;
         end else if (usepix_ff[dy]) begin
            q_data.vec[dy] = s1_pixel_ff;
         end else begin
            q_data.vec[dy] = rd_ff[sel_ff[dy]];
         end
      end
   end

   assign q_push = s1_valid_ff;

endmodule
`default_nettype wire

>>> rtl/mf2d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf2d_queue
// Short queue of window columns between the front and the back.
// ----------------------------------------------------------------------------
module mf2d_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr,
   input  mf2d_pkg::col_entry_type   wr_data,
   input  logic                      rd,
   output mf2d_pkg::col_entry_type   rd_data,
   output logic                      q_empty,
   output logic [mf2d_pkg::Q_AW:0]   q_count
);
   import mf2d_pkg::*;

   col_entry_type     slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [Q_AW:0]     cnt_ff, cnt_in;

   assign q_empty = cnt_ff == '0;
   assign q_count = cnt_ff;
   assign rd_data = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wr ? wp_ff + 1'b1 : wp_ff;
      rp_in  = rd ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (Q_AW+1)'(wr) - (Q_AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mf2d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf2d_back
// Slides window columns, masks taps outside the frame, finds the median by
// a bit-serial rank select (one bit per stage) and buffers the results.
// ----------------------------------------------------------------------------
module mf2d_back (
   input  logic                            clock,
   input  logic                            reset,
   input  mf2d_pkg::cfg_type               cfg,
   input  logic                            q_empty,
   input  mf2d_pkg::col_entry_type         q_data,
   output logic                            q_pop,
   output logic                            empty,
   input  logic                            pop,
   output logic [mf2d_pkg::PIX_W-1:0]      rsp_median,
   output logic [mf2d_pkg::COL_W-1:0]      rsp_out_x,
   output logic [mf2d_pkg::EROW_W-1:0]     rsp_out_y,
   output logic                            rsp_frame_last
);
   import mf2d_pkg::*;

   typedef struct packed {
      logic [COL_W-1:0]  x;
      logic [EROW_W-1:0] y;
      logic              last;
   } tag_type;

   typedef struct packed {
      pixel_type         median;
      logic [COL_W-1:0]  x;
      logic [EROW_W-1:0] y;
      logic              last;
   } result_type;

   col_vec_type        shift_ff [WIN_SIDE];
   tag_type            b0_ff;
   logic               b0_valid_ff;
   pixel_type          taps_in [WIN_TAPS];
   logic [POS_W-1:0]   col_pos [WIN_SIDE];
   logic [WIN_SIDE-1:0] col_ok;

   pixel_type          sv_ff   [PIX_W+1][WIN_TAPS];
   logic [WIN_TAPS-1:0] mask_ff [PIX_W+1];
   logic [RANK_W-1:0]  rank_ff [PIX_W+1];
   pixel_type          res_ff  [PIX_W+1];
   tag_type            tag_ff  [PIX_W+1];
   logic [PIX_W:0]     vld_ff;

   result_type         out_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]  owp_ff, orp_ff;
   logic [OUT_AW:0]    ocnt_ff, ocnt_in, credit_ff, credit_in;
   logic               out_take;

   // credit covers every emitting column between the queue and the buffer
   assign q_pop    = !q_empty && (credit_ff < (OUT_AW+1)'(OUT_DEPTH));
   assign out_take = pop & ~empty;
   assign empty    = ocnt_ff == '0;

   always_comb begin
      credit_in = credit_ff + (OUT_AW+1)'(q_pop & q_data.emit) - (OUT_AW+1)'(out_take);
      ocnt_in   = ocnt_ff + (OUT_AW+1)'(vld_ff[PIX_W]) - (OUT_AW+1)'(out_take);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         shift_ff[0] <= q_data.vec;
         for (int k = 1; k < WIN_SIDE; k++) begin
            shift_ff[k] <= shift_ff[k-1];
         end
         b0_ff.x    <= q_data.x;
         b0_ff.y    <= q_data.y;
         b0_ff.last <= q_data.last;
      end
   end

   // slot k holds column x + r - k of the window
   always_comb begin
      for (int k = 0; k < WIN_SIDE; k++) begin
         col_pos[k] = POS_W'(b0_ff.x) + POS_W'(cfg.r) - POS_W'(k);
         col_ok[k]  = ((RAD_W+1)'(k) <= {cfg.r, 1'b0}) && !col_pos[k][POS_W-1] &&
                      (col_pos[k] < POS_W'(cfg.w));
      end
      for (int k = 0; k < WIN_SIDE; k++) begin
         for (int dy = 0; dy < WIN_SIDE; dy++) begin
            taps_in[k*WIN_SIDE+dy] = col_ok[k] ? shift_ff[k][dy] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sv_ff[0]   <= taps_in;
      mask_ff[0] <= '1;
      rank_ff[0] <= median_rank(cfg.r);
      res_ff[0]  <= '0;
      tag_ff[0]  <= b0_ff;
   end

   for (genvar s = 0; s < PIX_W; s++) begin : g_sel
      localparam int BIT = PIX_W - 1 - s;
      logic [WIN_TAPS-1:0] zero_set;
      logic [CNT_W-1:0]    cnt;
      logic                take_zero;
      pixel_type           res_in;

      always_comb begin
         zero_set = '0;
         cnt      = '0;
         for (int i = 0; i < WIN_TAPS; i++) begin
            zero_set[i] = mask_ff[s][i] & ~sv_ff[s][i][BIT];
            cnt         = cnt + CNT_W'(zero_set[i]);
         end
         take_zero   = CNT_W'(rank_ff[s]) < cnt;
         res_in      = res_ff[s];
         res_in[BIT] = ~take_zero;
      end

      always_ff @(posedge clock) begin
         sv_ff[s+1]  <= sv_ff[s];
         res_ff[s+1] <= res_in;
         tag_ff[s+1] <= tag_ff[s];
         if (take_zero) begin
            mask_ff[s+1] <= zero_set;
            rank_ff[s+1] <= rank_ff[s];
         end else begin
            mask_ff[s+1] <= mask_ff[s] & ~zero_set;
            rank_ff[s+1] <= rank_ff[s] - cnt[RANK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         vld_ff      <= '0;
         owp_ff      <= '0;
         orp_ff      <= '0;
         ocnt_ff     <= '0;
         credit_ff   <= '0;
      end else begin
         b0_valid_ff <= q_pop & q_data.emit;
         vld_ff      <= {vld_ff[PIX_W-1:0], b0_valid_ff};
         if (vld_ff[PIX_W]) begin
            owp_ff <= owp_ff + 1'b1;
         end
         if (out_take) begin
            orp_ff <= orp_ff + 1'b1;
         end
         ocnt_ff   <= ocnt_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_ff[PIX_W]) begin
         out_ff[owp_ff] <= '{median: res_ff[PIX_W], x: tag_ff[PIX_W].x,
                             y: tag_ff[PIX_W].y, last: tag_ff[PIX_W].last};
      end
   end

   assign rsp_median     = out_ff[orp_ff].median;
   assign rsp_out_x      = out_ff[orp_ff].x;
   assign rsp_out_y      = out_ff[orp_ff].y;
   assign rsp_frame_last = out_ff[orp_ff].last;

endmodule
`default_nettype wire

>>> rtl/median_filter_2d_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_2d_top
// Streaming (2r+1)x(2r+1) median filter for 8-bit grayscale frames.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock in raster order unless full and returns one
// median beat per clock once the window is primed and pop is held: the median
// for a position comes out after the beat r rows plus r pixels later has been
// pushed and has passed the front stage, the queue, the column stage, the tap
// register and eight rank-select stages, one per pixel bit. Pixels outside
// the frame count as zero; after the last pixel, flush beats (cmd = 1) drain
// the remaining r rows plus r pixels. Rows live in eight single-port-read row
// banks, read at one address per beat. Writing a size or radius register
// restarts the frame; write registers only while the block is idle.
module median_filter_2d_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_cmd,
   input  logic [mf2d_pkg::PIX_W-1:0]       req_pixel,
   output logic                             empty,
   input  logic                             pop,
   output logic [mf2d_pkg::PIX_W-1:0]       rsp_median,
   output logic [mf2d_pkg::COL_W-1:0]       rsp_out_x,
   output logic [mf2d_pkg::EROW_W-1:0]      rsp_out_y,
   output logic                             rsp_frame_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [mf2d_pkg::CSR_AW-1:0]      paddr,
   input  logic [mf2d_pkg::CSR_DW-1:0]      pwdata,
   output logic [mf2d_pkg::CSR_DW-1:0]      prdata,
   output logic                             pready
);
   import mf2d_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [RAD_W-1:0] radius_ff, radius_in;
   logic             csr_wr, restart;
   logic [1:0]       reg_idx;
   cfg_type          cfg;
   logic             q_push, q_pop, q_empty;
   logic [Q_AW:0]    q_count;
   col_entry_type    q_wr_data, q_rd_data;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign reg_idx = paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      restart   = 1'b0;
      if (csr_wr) begin
         case (reg_idx)
            REG_FRAME_WIDTH: begin
               width_in = pwdata[DIM_W-1:0];
               restart  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in = pwdata[DIM_W-1:0];
               restart   = 1'b1;
            end
            REG_WINDOW_RADIUS: begin
               radius_in = pwdata[RAD_W-1:0];
               restart   = 1'b1;
            end
            default: restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         radius_ff <= RAD_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FRAME_WIDTH:   prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT:  prdata = CSR_DW'(height_ff);
         REG_WINDOW_RADIUS: prdata = CSR_DW'(radius_ff);
         default:           prdata = '0;
      endcase
   end

   // zero acts as one, oversize values clamp to the maximum
   always_comb begin
      if (width_ff == '0) begin
         cfg.w = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         cfg.w = DIM_W'(MAX_WIDTH);
      end else begin
         cfg.w = width_ff;
      end
      if (height_ff == '0) begin
         cfg.h = DIM_W'(1);
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         cfg.h = DIM_W'(MAX_HEIGHT);
      end else begin
         cfg.h = height_ff;
      end
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         cfg.r = RAD_W'(MAX_RADIUS);
      end else begin
         cfg.r = radius_ff;
      end
   end

   mf2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .restart   (restart),
      .push      (push),
      .full      (full),
      .req_cmd   (req_cmd),
      .req_pixel (req_pixel),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_data    (q_wr_data)
   );

   mf2d_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_push),
      .wr_data (q_wr_data),
      .rd      (q_pop),
      .rd_data (q_rd_data),
      .q_empty (q_empty),
      .q_count (q_count)
   );

   mf2d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_empty        (q_empty),
      .q_data         (q_rd_data),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_median     (rsp_median),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
`default_nettype wire

>>> tb/mf2d_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mf2d_tb_pkg
// Beat codes shared by the median filter testbench files.
// ----------------------------------------------------------------------------
package mf2d_tb_pkg;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } beat_cmd_type;

endpackage

>>> tb/mf2d_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mf2d_checker
// Watches the pixel, median and register ports of the median filter, keeps
// its own model of the frame state and checks every median beat in order.
// ----------------------------------------------------------------------------
module mf2d_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic                          full,
   input  logic                          req_cmd,
   input  logic [mf2d_pkg::PIX_W-1:0]    req_pixel,
   input  logic                          empty,
   input  logic                          pop,
   input  logic [mf2d_pkg::PIX_W-1:0]    rsp_median,
   input  logic [mf2d_pkg::COL_W-1:0]    rsp_out_x,
   input  logic [mf2d_pkg::EROW_W-1:0]   rsp_out_y,
   input  logic                          rsp_frame_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [mf2d_pkg::CSR_AW-1:0]   paddr,
   input  logic [mf2d_pkg::CSR_DW-1:0]   pwdata,
   output int                            fail_count,
   output int                            medians_pending
);
   import mf2d_pkg::*;
   import mf2d_tb_pkg::*;

   localparam int HIST_ROWS = 3 * MAX_RADIUS + 1;

   typedef struct {
      logic [PIX_W-1:0]  median;
      logic [COL_W-1:0]  x;
      logic [EROW_W-1:0] y;
      logic              last;
   } median_beat_type;

   logic [PIX_W-1:0]  row_hist [HIST_ROWS*MAX_WIDTH];
   logic [DIM_W-1:0]  cfg_w, cfg_h;
   logic [RAD_W-1:0]  cfg_r;
   int                in_col, in_row, out_col, out_row;
   median_beat_type   expected_medians [$];

   function automatic int eff_w();
      if (cfg_w == 0) return 1;
      return (cfg_w > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_w);
   endfunction

   function automatic int eff_h();
      if (cfg_h == 0) return 1;
      return (cfg_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_h);
   endfunction

   function automatic logic [PIX_W-1:0] window_median(int w, int h, int r);
      int taps [WIN_TAPS];
      int n, key, j, y, x;
      n = 0;
      for (int dy = -r; dy <= r; dy++) begin
         for (int dx = -r; dx <= r; dx++) begin
            y = out_row + dy;
            x = out_col + dx;
            if (y >= 0 && x >= 0 && y < h && x < w)
               taps[n] = row_hist[(y % HIST_ROWS) * MAX_WIDTH + x];
            else
               taps[n] = 0;
            n++;
         end
      end
      for (int i = 1; i < n; i++) begin
         key = taps[i];
         j = i;
         while (j > 0 && taps[j-1] > key) begin
            taps[j] = taps[j-1];
            j--;
         end
         taps[j] = key;
      end
      return PIX_W'(taps[n/2]);
   endfunction

   task automatic predict_beat(input logic cmd, input logic [PIX_W-1:0] pix);
      int w, h, r, taken, done, total;
      median_beat_type m;
      w = eff_w();
      h = eff_h();
      r = int'(cfg_r);
      if (in_row < h) begin
         if (cmd == CMD_FLUSH) return;   // flush before frame end is dropped
         row_hist[(in_row % HIST_ROWS) * MAX_WIDTH + in_col] = pix;
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      taken = in_row * w + in_col;
      done  = out_row * w + out_col;
      total = w * h;
      if (done >= total || taken < done + r * w + r + 1) return;
      m.median = window_median(w, h, r);
      m.x      = COL_W'(out_col);
      m.y      = EROW_W'(out_row);
      m.last   = (done == total - 1);
      expected_medians.push_back(m);
      if (m.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   always @(posedge clock) begin
      median_beat_type m;
      logic hit;
      if (reset) begin
         cfg_w = 640; cfg_h = 480; cfg_r = 1;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         expected_medians.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            hit = 1'b1;
            case (paddr[CSR_AW-1:2])
               REG_FRAME_WIDTH:   cfg_w = pwdata[DIM_W-1:0];
               REG_FRAME_HEIGHT:  cfg_h = pwdata[DIM_W-1:0];
               REG_WINDOW_RADIUS: cfg_r = pwdata[RAD_W-1:0];
               default:           hit = 1'b0;
            endcase
            // only a known register restarts the frame
            if (hit) begin
               in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            end
         end
         if (push && !full)
            predict_beat(req_cmd, req_pixel);
         if (pop && !empty) begin
            if (expected_medians.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected median beat: med=%0d x=%0d y=%0d last=%0b",
                           rsp_median, rsp_out_x, rsp_out_y, rsp_frame_last);
            end else begin
               m = expected_medians.pop_front();
               if (rsp_median !== m.median || rsp_out_x !== m.x ||
                   rsp_out_y !== m.y || rsp_frame_last !== m.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"median mismatch: exp med=%0d x=%0d y=%0d last=%0b,",
                               " got med=%0d x=%0d y=%0d last=%0b"},
                              m.median, m.x, m.y, m.last,
                              rsp_median, rsp_out_x, rsp_out_y, rsp_frame_last);
               end
            end
         end
      end
      medians_pending = expected_medians.size();
   end

endmodule

>>> tb/tb_median_filter_2d_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_filter_2d_top
// Frame-level regression of the streaming 2D median filter.
// ----------------------------------------------------------------------------
// Drives whole frames of random sizes and radii, with early flushes, late
// pixels and bursty pixel beats, while the median side stalls at random and
// once holds off long enough to back up the input. The checker predicts and
// compares every median beat.
module tb_median_filter_2d_top;
   import mf2d_pkg::*;
   import mf2d_tb_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic                req_cmd = CMD_PIXEL;
   logic [PIX_W-1:0]    req_pixel = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [PIX_W-1:0]    rsp_median;
   logic [COL_W-1:0]    rsp_out_x;
   logic [EROW_W-1:0]   rsp_out_y;
   logic                rsp_frame_last;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [CSR_AW-1:0]   paddr = '0;
   logic [CSR_DW-1:0]   pwdata = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;
   int                  fail_count;
   int                  medians_pending;
   int                  beats_sent = 0;
   int                  burst_left = 8;
   int                  pops_done = 0;

   median_filter_2d_top uut (
      .clock, .reset, .push, .full, .req_cmd, .req_pixel,
      .empty, .pop, .rsp_median, .rsp_out_x, .rsp_out_y, .rsp_frame_last,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   mf2d_checker chk (
      .clock, .reset, .push, .full, .req_cmd, .req_pixel,
      .empty, .pop, .rsp_median, .rsp_out_x, .rsp_out_y, .rsp_frame_last,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .medians_pending
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("median_filter_2d_top regression: fail");
      $finish;
   end

   // median side: stall mode changes at random, one long hold-off
   initial begin
      int mode, hold;
      mode = 0;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) pops_done++;
         if (pops_done == 200 && hold == 0) hold = 400;
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
         if (hold > 1) begin
            pop <= 1'b0;
            hold--;
            if (hold == 1) pops_done++;   // one-shot
         end else case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic send_beat(input logic cmd, input logic [PIX_W-1:0] pix);
      int gap;
      req_cmd   <= cmd;
      req_pixel <= pix;
      push      <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input int val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= CSR_DW'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // one frame: wait for idle, registers, pixels with stray early flushes, then the drain
   task automatic run_frame(input int w, input int h, input int r, input int noise);
      int ew, eh;
      push <= 1'b0;
      @(posedge clock);
      while (medians_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_WINDOW_RADIUS, r);
      ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      for (int i = 0; i < ew * eh; i++) begin
         if ($urandom_range(0, 99) < noise) send_beat(CMD_FLUSH, rand_pixel());
         send_beat(CMD_PIXEL, rand_pixel());
      end
      // pixels arriving here are late and act as flushes
      for (int i = 0; i < r * ew + r; i++)
         send_beat(($urandom_range(0, 2) == 0) ? CMD_PIXEL : CMD_FLUSH, rand_pixel());
      if ($urandom_range(0, 1) == 1) send_beat(CMD_FLUSH, rand_pixel());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray flush, extreme pixels, late pixels, degenerate sizes
      csr_write(REG_FRAME_WIDTH, 3);
      csr_write(REG_FRAME_HEIGHT, 2);
      csr_write(REG_WINDOW_RADIUS, 1);
      send_beat(CMD_FLUSH, 8'hFF);
      send_beat(CMD_PIXEL, 8'h00);
      send_beat(CMD_PIXEL, 8'hFF);
      send_beat(CMD_PIXEL, 8'hAA);
      send_beat(CMD_PIXEL, 8'h55);
      send_beat(CMD_PIXEL, 8'hFF);
      send_beat(CMD_PIXEL, 8'h00);
      send_beat(CMD_FLUSH, 8'h00);
      send_beat(CMD_PIXEL, 8'h7F);
      send_beat(CMD_FLUSH, 8'h00);
      send_beat(CMD_FLUSH, 8'h00);
      send_beat(CMD_FLUSH, 8'h00);
      run_frame(0, 0, 0, 0);
      run_frame(1, 1, 3, 0);
      run_frame(4, 3, 3, 20);
      // oversize width; the long hold-off lands inside this frame
      run_frame(2047, 1, 0, 0);

      while (beats_sent < 1300)
         run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 3), 5);

      push <= 1'b0;
      @(posedge clock);
      while (medians_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("median_filter_2d_top regression: pass");
      else
         $display("median_filter_2d_top regression: fail");
      $finish;
   end

endmodule
